// ----- design/sdz_pkg.sv -----
// ----------------------------------------------------------------------------
// sdz_pkg
// Shared widths, register indexes and the CORDIC arctangent table for the
// stick dead zone heading block.
// ----------------------------------------------------------------------------
package sdz_pkg;

    localparam int AXIS_W  = 8;
    localparam int VALUE_W = 16;
    localparam int HEAD_W  = 9;
    localparam int CIDX_W  = 8;
    localparam int CDAT_W  = 16;
    localparam int ZONE_W  = 15;
    localparam int CORD_W  = 35;
    localparam int ANG_W   = 24;
    localparam int STEP_W  = 4;

    localparam logic [CIDX_W-1:0] CFG_DEAD_ZONE_LOW = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_OUTER_ZONE    = 8'd1;

    localparam logic [ZONE_W-1:0] FULL_SCALE     = 15'd32767;
    localparam logic [ZONE_W-1:0] DZ_LOW_RESET   = 15'd8192;
    localparam logic [ZONE_W-1:0] OUTER_RESET    = 15'd0;
    localparam logic [ANG_W-1:0]  ANG_MAX        = 24'd5898239;

    localparam logic [HEAD_W-1:0] BASE_Q0 = 9'd0;
    localparam logic [HEAD_W-1:0] BASE_Q1 = 9'd90;
    localparam logic [HEAD_W-1:0] BASE_Q2 = 9'd180;
    localparam logic [HEAD_W-1:0] BASE_Q3 = 9'd270;

    // arctan(2^-i) in degrees, Q8.16
    function automatic logic [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
        logic [ANG_W-1:0] res;
        case (idx)
            4'd0:    res = 24'd2949120;
            4'd1:    res = 24'd1740967;
            4'd2:    res = 24'd919879;
            4'd3:    res = 24'd466945;
            4'd4:    res = 24'd234379;
            4'd5:    res = 24'd117304;
            4'd6:    res = 24'd58666;
            4'd7:    res = 24'd29335;
            4'd8:    res = 24'd14668;
            4'd9:    res = 24'd7334;
            4'd10:   res = 24'd3667;
            4'd11:   res = 24'd1833;
            4'd12:   res = 24'd917;
            4'd13:   res = 24'd458;
            4'd14:   res = 24'd229;
            default: res = 24'd115;
        endcase
        return res;
    endfunction

endpackage

// ----- design/sdz_if.sv -----
// ----------------------------------------------------------------------------
// sdz_if
// Valid/ready channels of the stick dead zone heading block: axis requests,
// heading results and register writes.
// ----------------------------------------------------------------------------
interface sdz_in_if import sdz_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [AXIS_W-1:0]         axis_index;
    logic signed [VALUE_W-1:0] axis_value;

    modport source (output valid, axis_index, axis_value, input ready);
    modport sink   (input valid, axis_index, axis_value, output ready);
endinterface

interface sdz_out_if import sdz_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HEAD_W-1:0] heading_degrees;

    modport source (output valid, heading_degrees, input ready);
    modport sink   (input valid, heading_degrees, output ready);
endinterface

interface sdz_cfg_if import sdz_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/stick_dead_zone_heading.sv -----
// ----------------------------------------------------------------------------
// stick_dead_zone_heading
// Per-axis dead zone on joystick axis events, then the clockwise heading.
//
// i_in carries one axis request (axis_index, axis_value). Axis 0 sets x
// (negated), axis 1 sets y; other axes and values inside the dead zone give
// no result. o_res carries the heading in whole degrees, 0..359. i_cfg
// writes register 0 (dead_zone_low) and register 1 (outer_zone); it is
// always ready, and the user must write it only while the block is idle;
// the block does not enforce this. A request passes a zone check, 15
// divide steps, a setup step, 16 CORDIC steps and a result step; the
// divide is skipped when the magnitude saturates. A request on another
// axis is dropped at acceptance; one inside the dead zone frees the block
// after the zone check. One request is in flight at a time; the block takes
// no new one until the bit-serial divider and iterative CORDIC unit are
// through with the last. A finished heading waits in the output register;
// the block accepts the next request meanwhile, and holds its own result
// in the last step while the receiver stalls. Reset clears the last x and
// y values, the output valid and returns the registers to 8192 and 0.
// ----------------------------------------------------------------------------
module stick_dead_zone_heading import sdz_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdz_in_if.sink    i_in,
    sdz_cfg_if.sink   i_cfg,
    sdz_out_if.source o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZONE,
        S_DIV,
        S_COMB,
        S_CORD,
        S_DONE
    } t_state;

    t_state r_state;

    logic                       r_axis_y;
    logic signed [VALUE_W-1:0]  r_v;
    logic [ZONE_W-1:0]          r_dz_low;
    logic [ZONE_W-1:0]          r_outer;
    logic signed [VALUE_W-1:0]  r_last_x;
    logic signed [VALUE_W-1:0]  r_last_y;
    logic [ZONE_W-1:0]          r_rem;
    logic [ZONE_W-1:0]          r_num;
    logic [ZONE_W-1:0]          r_quo;
    logic [ZONE_W-1:0]          r_div;
    logic [STEP_W-1:0]          r_cnt;
    logic signed [CORD_W-1:0]   r_cx;
    logic signed [CORD_W-1:0]   r_cy;
    logic signed [ANG_W-1:0]    r_z;
    logic [HEAD_W-1:0]          r_base;
    logic [HEAD_W-1:0]          r_heading;
    logic                       r_out_valid;

    logic signed [VALUE_W-1:0]  w_clamped;
    logic [ZONE_W-1:0]          w_mag;
    logic                       w_pass;
    logic [ZONE_W-1:0]          w_diff;
    logic signed [ZONE_W+1:0]   w_range;
    logic                       w_range_pos;
    logic                       w_sat;
    logic [2*ZONE_W-1:0]        w_prod;
    logic [ZONE_W:0]            w_trial;
    logic [ZONE_W:0]            w_sub;
    logic                       w_ge;
    logic                       w_neg;
    logic signed [VALUE_W-1:0]  w_comp;
    logic signed [VALUE_W-1:0]  w_x;
    logic signed [VALUE_W-1:0]  w_y;
    logic [VALUE_W-1:0]         w_a;
    logic [VALUE_W-1:0]         w_b;
    logic [HEAD_W-1:0]          w_base;
    logic signed [CORD_W-1:0]   w_dx;
    logic signed [CORD_W-1:0]   w_dy;
    logic [ANG_W-1:0]           w_tab;
    logic [ANG_W-1:0]           w_zc;
    logic [HEAD_W-1:0]          w_heading;
    logic                       w_out_free;

    assign i_in.ready            = (r_state == S_IDLE);
    assign i_cfg.ready           = 1'b1;
    assign o_res.valid           = r_out_valid;
    assign o_res.heading_degrees = r_heading;
    assign w_out_free            = !r_out_valid || o_res.ready;

    always_comb begin
        w_clamped = (i_in.axis_value == 16'sh8000) ? -16'sd32767 : i_in.axis_value;
    end

    always_comb begin
        w_mag       = r_v[VALUE_W-1] ? ZONE_W'(-r_v) : r_v[ZONE_W-1:0];
        w_pass      = w_mag > r_dz_low;
        w_diff      = w_mag - r_dz_low;
        w_range     = $signed({2'b00, FULL_SCALE}) - $signed({2'b00, r_outer})
                    - $signed({2'b00, r_dz_low});
        w_range_pos = !w_range[ZONE_W+1] && (w_range != '0);
        w_sat       = !w_range_pos || (w_diff >= w_range[ZONE_W-1:0]);
        w_prod      = {w_diff, {ZONE_W{1'b0}}} - {{ZONE_W{1'b0}}, w_diff};
    end

    always_comb begin
        w_trial = {r_rem, r_num[ZONE_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_sub   = w_trial - {1'b0, r_div};
    end

    always_comb begin
        w_neg  = r_v[VALUE_W-1] ^ !r_axis_y;
        w_comp = w_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        w_x    = r_axis_y ? r_last_x : w_comp;
        w_y    = r_axis_y ? w_comp : r_last_y;
        if (!w_x[VALUE_W-1] && !w_y[VALUE_W-1] && w_y != '0) begin
            w_base = BASE_Q0; w_a = w_x;  w_b = w_y;
        end else if (!w_x[VALUE_W-1] && w_x != '0) begin
            w_base = BASE_Q1; w_a = -w_y; w_b = w_x;
        end else if (w_y[VALUE_W-1]) begin
            w_base = BASE_Q2; w_a = -w_x; w_b = -w_y;
        end else begin
            w_base = BASE_Q3; w_a = w_y;  w_b = -w_x;
        end
    end

    always_comb begin
        w_dx = r_cy >>> r_cnt;
        w_dy = r_cx >>> r_cnt;
        w_tab = atan_step(r_cnt);
        if (r_z[ANG_W-1]) begin
            w_zc = '0;
        end else if (r_z > $signed(ANG_MAX)) begin
            w_zc = ANG_MAX;
        end else begin
            w_zc = r_z;
        end
        w_heading = r_base + HEAD_W'(w_zc[ANG_W-1:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dz_low    <= DZ_LOW_RESET;
            r_outer     <= OUTER_RESET;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_DEAD_ZONE_LOW) begin
                    r_dz_low <= i_cfg.data[ZONE_W-1:0];
                end else if (i_cfg.index == CFG_OUTER_ZONE) begin
                    r_outer <= i_cfg.data[ZONE_W-1:0];
                end
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.axis_index < AXIS_W'(2)) begin
                        r_axis_y <= i_in.axis_index[0];
                        r_v      <= w_clamped;
                        r_state  <= S_ZONE;
                    end
                end
                S_ZONE: begin
                    r_div <= w_range[ZONE_W-1:0];
                    r_rem <= w_prod[2*ZONE_W-1:ZONE_W];
                    r_num <= w_prod[ZONE_W-1:0];
                    r_cnt <= '0;
                    if (!w_pass) begin
                        r_state <= S_IDLE;
                    end else if (w_sat) begin
                        r_quo   <= FULL_SCALE;
                        r_state <= S_COMB;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_sub[ZONE_W-1:0] : w_trial[ZONE_W-1:0];
                    r_num <= {r_num[ZONE_W-2:0], 1'b0};
                    r_quo <= {r_quo[ZONE_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(ZONE_W - 1)) begin
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    if (r_axis_y) begin
                        r_last_y <= w_comp;
                    end else begin
                        r_last_x <= w_comp;
                    end
                    r_base  <= w_base;
                    r_cx    <= $signed({{(CORD_W-VALUE_W-16){1'b0}}, w_b, 16'd0});
                    r_cy    <= $signed({{(CORD_W-VALUE_W-16){1'b0}}, w_a, 16'd0});
                    r_z     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_cy[CORD_W-1]) begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_z  <= r_z + $signed(w_tab);
                    end else begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_z  <= r_z - $signed(w_tab);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_heading <= w_heading;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/stick_dead_zone_heading_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stick_dead_zone_heading_tb
// Self-checking bench for the stick dead zone heading block. Axis requests
// go through a dead zone and heading model kept in a scoreboard class. Each
// heading the block returns is checked against the oldest predicted one.
// Zone registers are rewritten between phases while the block is idle.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module stick_dead_zone_heading_tb;
    import sdz_pkg::*;

    localparam logic [AXIS_W-1:0] AXIS_X = 8'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_UNUSED_NEXT = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_UNUSED_TOP  = 8'hFF;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    class heading_tracker;
        int unsigned zone_low;
        int unsigned zone_outer;
        int          last_x;
        int          last_y;
        longint      atan_q16[16];
        int          pending_headings[$];
        int          mismatches;
        int          headings_checked;

        function new();
            zone_low         = DZ_LOW_RESET;
            zone_outer       = OUTER_RESET;
            last_x           = 0;
            last_y           = 0;
            mismatches       = 0;
            headings_checked = 0;
            atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        endfunction

        function int pending();
            return pending_headings.size();
        endfunction

        function void write_register(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
            if (idx == CFG_DEAD_ZONE_LOW) begin
                zone_low = data[ZONE_W-1:0];
            end else if (idx == CFG_OUTER_ZONE) begin
                zone_outer = data[ZONE_W-1:0];
            end
        endfunction

        function int bearing_from(int x, int y);
            longint a, b, cx, cy, z, dx, dy;
            int     base;
            if (x == 0 && y == 0) begin
                return 0;
            end
            if (x >= 0 && y > 0) begin
                base = BASE_Q0; a = x;  b = y;
            end else if (x > 0 && y <= 0) begin
                base = BASE_Q1; a = -y; b = x;
            end else if (x <= 0 && y < 0) begin
                base = BASE_Q2; a = -x; b = -y;
            end else begin
                base = BASE_Q3; a = y;  b = -x;
            end
            cx = b * 65536;
            cy = a * 65536;
            z  = 0;
            for (int i = 0; i < 16; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx += dx; cy -= dy; z += atan_q16[i];
                end else begin
                    cx -= dx; cy += dy; z -= atan_q16[i];
                end
            end
            if (z < 0) begin
                z = 0;
            end
            if (z > longint'(ANG_MAX)) begin
                z = ANG_MAX;
            end
            return base + int'(z >>> 16);
        endfunction

        function void note_request(logic [AXIS_W-1:0] axis, logic signed [VALUE_W-1:0] value);
            int     v, mag, span, n, comp;
            longint q;
            if (axis > AXIS_Y) begin
                return;
            end
            v = value;
            if (v < -int'(FULL_SCALE)) begin
                v = -int'(FULL_SCALE);
            end
            mag = (v < 0) ? -v : v;
            if (mag <= int'(zone_low)) begin
                return;
            end
            span = int'(FULL_SCALE) - int'(zone_outer) - int'(zone_low);
            if (span > 0) begin
                q = longint'(mag - int'(zone_low)) * int'(FULL_SCALE) / span;
                n = (q > int'(FULL_SCALE)) ? int'(FULL_SCALE) : int'(q);
            end else begin
                n = FULL_SCALE;
            end
            comp = (v < 0) ? -n : n;
            if (axis == AXIS_X) begin
                last_x = -comp;
            end else begin
                last_y = comp;
            end
            pending_headings = {pending_headings, bearing_from(last_x, last_y)};
        endfunction

        function void check_heading(logic [HEAD_W-1:0] got);
            int want;
            if (pending_headings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected heading %0d with nothing predicted", got);
                end
                return;
            end
            want = pending_headings.pop_front();
            headings_checked++;
            if (got !== want[HEAD_W-1:0]) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("heading mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sdz_in_if  in_ch ();
    sdz_out_if res_ch ();
    sdz_cfg_if cfg_ch ();

    stick_dead_zone_heading u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    heading_tracker tracker = new();
    bit tx_stall_on = 1'b1;
    bit rx_stall_on = 1'b1;
    int rx_hold     = 0;
    int idle_cycles = 0;
    int axis_requests    = 0;
    int ignored_requests = 0;
    int zone_settings    = 1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            rx_hold = 0;
        end else if (res_ch.valid && res_ch.ready) begin
            tracker.check_heading(res_ch.heading_degrees);
            rx_hold = rx_stall_on ? $urandom_range(0, 15) : 0;
            if (rx_hold != 0) begin
                res_ch.ready <= 1'b0;
            end
        end else if (!res_ch.ready) begin
            if (rx_hold > 0) begin
                rx_hold--;
            end
            if (rx_hold == 0) begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        do begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end while (idle_cycles < STALL_LIMIT);
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("stick_dead_zone_heading verification failed");
        $finish;
    end

    task automatic send_axis(input logic [AXIS_W-1:0] axis,
                             input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = tx_stall_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.axis_index <= axis;
        in_ch.axis_value <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_request(axis, value);
        if (axis > AXIS_Y) begin
            ignored_requests++;
        end else begin
            axis_requests++;
        end
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.write_register(idx, data);
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic settle();
        cfg_ch.valid <= 1'b0;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(int unsigned low);
        int mag;
        mag = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: return VALUE_W'($urandom);
            3, 4: begin
                mag = int'(low) + int'($urandom_range(0, 2)) - 1;
                if (mag < 0) mag = 0;
                if (mag > int'(FULL_SCALE)) mag = FULL_SCALE;
            end
            5: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh8001;
                    default: return 16'sh0000;
                endcase
            end
            default: mag = $urandom_range(int'(FULL_SCALE), low);
        endcase
        return $urandom_range(0, 1) ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    task automatic run_phase(input logic [CDAT_W-1:0] low_data,
                             input logic [CDAT_W-1:0] outer_data,
                             input int count, input bit stray_writes, input bit mid_pause);
        int sent;
        settle();
        write_reg(CFG_DEAD_ZONE_LOW, low_data);
        write_reg(CFG_OUTER_ZONE, outer_data);
        if (stray_writes) begin
            write_reg(CFG_UNUSED_NEXT, 16'h1234);
            write_reg(CFG_UNUSED_TOP, 16'hFFFF);
        end
        cfg_ch.valid <= 1'b0;
        zone_settings++;
        tx_stall_on = $urandom_range(0, 3) != 0;
        rx_stall_on = $urandom_range(0, 3) != 0;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_axis(AXIS_W'($urandom_range(2, 255)), VALUE_W'($urandom));
            end else begin
                send_axis($urandom_range(0, 1) ? AXIS_Y : AXIS_X, pick_value(tracker.zone_low));
                sent++;
                if (mid_pause && sent == count / 2) begin
                    hold_until_drained();
                end
            end
        end
    endtask

    task automatic directed_part();
        send_axis(AXIS_X, 16'sh7FFF);
        send_axis(AXIS_Y, 16'sh7FFF);
        send_axis(AXIS_Y, 16'sh8000);
        send_axis(AXIS_X, 16'sh8000);
        send_axis(AXIS_X, 16'sd8192);
        send_axis(AXIS_X, 16'sd8193);
        send_axis(AXIS_Y, -16'sd8192);
        send_axis(AXIS_Y, -16'sd8193);
        send_axis(8'd2, 16'sh7FFF);
        send_axis(8'hFF, 16'sh8000);
        send_axis(8'h80, 16'sd1234);
        send_axis(AXIS_X, 16'sd0);
        send_axis(AXIS_Y, -16'sd1);
        send_axis(AXIS_X, 16'sd20000);
        send_axis(AXIS_Y, 16'sd0);
        send_axis(AXIS_X, -16'sd20000);
        send_axis(AXIS_Y, 16'sd20000);
        send_axis(AXIS_X, 16'sd1);
        send_axis(AXIS_Y, 16'sh8001);
        send_axis(AXIS_X, 16'sh5555);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.axis_index <= '0;
        in_ch.axis_value <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();
        run_phase(16'd0, 16'd0, 150, 1'b0, 1'b1);
        run_phase(16'hFFFF, 16'h0000, 20, 1'b1, 1'b0);
        run_phase(16'd16384, 16'hFFFF, 80, 1'b0, 1'b0);
        run_phase(16'd100, 16'd1000, 150, 1'b0, 1'b0);
        repeat (3) begin
            run_phase({1'($urandom), 15'($urandom_range(0, 20000))},
                      {1'($urandom), 15'($urandom)}, 90, 1'b0, 1'b0);
        end
        run_phase(16'd8192, 16'd24575, 60, 1'b0, 1'b0);
        settle();

        $display("%0d axis requests and %0d on unused axes over %0d zone settings",
                 axis_requests, ignored_requests, zone_settings);
        $display("%0d headings checked, %0d mismatches",
                 tracker.headings_checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("stick_dead_zone_heading verification clean");
        end else begin
            $display("stick_dead_zone_heading verification failed");
        end
        $finish;
    end

endmodule
